>>> hw/rtl/fgr_pkg.sv
// Shared types, constants and the 5x7 font ROM for the glyph rasterizer.
// No dependencies; imported by every module of the block.
`default_nettype none

package fgr_pkg;

  localparam int GLYPH_ROWS    = 7;
  localparam int GLYPH_COLUMNS = 5;
  localparam int GLYPH_COUNT   = 95;
  localparam int ROW_W         = $clog2(GLYPH_ROWS);
  localparam int COL_W         = $clog2(GLYPH_COLUMNS);
  localparam int GLYPH_IDX_W   = $clog2(GLYPH_COUNT);

  localparam int QUEUE_DEPTH_DEFAULT = 2;

  localparam logic [7:0]  FIRST_CODE   = 8'd32;
  localparam logic [7:0]  LAST_CODE    = 8'd126;
  localparam logic [7:0]  NEWLINE_CODE = 8'd10;
  localparam logic [15:0] COORD_MAX    = 16'hFFFF;

  // Offsets added to a coordinate: col/row * scale, 6 * scale, 8 * scale + 2
  localparam int OFS_W = 7;

  typedef enum logic [2:0] {
    REG_ORIGIN_X    = 3'd0,
    REG_ORIGIN_Y    = 3'd1,
    REG_PIXEL_SCALE = 3'd2,
    REG_COLOR_RED   = 3'd3,
    REG_COLOR_GREEN = 3'd4,
    REG_COLOR_BLUE  = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       first;
  } char_item_t;

  typedef struct packed {
    logic [15:0] dot_x;
    logic [15:0] dot_y;
    logic [3:0]  dot_size;
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic        last;
  } dot_item_t;

  typedef struct packed {
    logic [11:0] origin_x;
    logic [11:0] origin_y;
    logic [3:0]  pixel_scale;
    logic [7:0]  color_red;
    logic [7:0]  color_green;
    logic [7:0]  color_blue;
  } cfg_t;

  // Row 0 is the top row; within a row the MSB is the leftmost column.
  typedef logic [0:GLYPH_ROWS-1][GLYPH_COLUMNS-1:0] glyph_t;

  typedef struct packed {
    glyph_t      glyph;
    logic [15:0] cursor_x;
    logic [15:0] cursor_y;
  } glyph_job_t;

  function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [OFS_W-1:0] b);
    logic [16:0] s;
    s = {1'b0, a} + 17'(b);
    sat_add = s[16] ? COORD_MAX : s[15:0];
  endfunction

  function automatic glyph_t font_glyph(input logic [GLYPH_IDX_W-1:0] idx);
    glyph_t g;
    unique case (idx)
      7'd0:  g = {5'd0,5'd0,5'd0,5'd0,5'd0,5'd0,5'd0};
      7'd1:  g = {5'd4,5'd4,5'd4,5'd4,5'd0,5'd4,5'd0};
      7'd2:  g = {5'd10,5'd10,5'd0,5'd0,5'd0,5'd0,5'd0};
      7'd3:  g = {5'd10,5'd10,5'd31,5'd10,5'd31,5'd10,5'd10};
      7'd4:  g = {5'd4,5'd15,5'd20,5'd14,5'd5,5'd30,5'd4};
      7'd5:  g = {5'd18,5'd18,5'd2,5'd4,5'd8,5'd9,5'd9};
      7'd6:  g = {5'd8,5'd20,5'd20,5'd8,5'd21,5'd18,5'd13};
      7'd7:  g = {5'd4,5'd4,5'd0,5'd0,5'd0,5'd0,5'd0};
      7'd8:  g = {5'd2,5'd4,5'd8,5'd8,5'd8,5'd4,5'd2};
      7'd9:  g = {5'd8,5'd4,5'd2,5'd2,5'd2,5'd4,5'd8};
      7'd10: g = {5'd0,5'd4,5'd21,5'd14,5'd21,5'd4,5'd0};
      7'd11: g = {5'd0,5'd4,5'd4,5'd31,5'd4,5'd4,5'd0};
      7'd12: g = {5'd0,5'd0,5'd0,5'd0,5'd0,5'd4,5'd8};
      7'd13: g = {5'd0,5'd0,5'd0,5'd31,5'd0,5'd0,5'd0};
      7'd14: g = {5'd0,5'd0,5'd0,5'd0,5'd0,5'd4,5'd0};
      7'd15: g = {5'd1,5'd1,5'd2,5'd4,5'd8,5'd16,5'd16};
      7'd16: g = {5'd14,5'd17,5'd19,5'd21,5'd25,5'd17,5'd14};
      7'd17: g = {5'd4,5'd12,5'd4,5'd4,5'd4,5'd4,5'd14};
      7'd18: g = {5'd14,5'd17,5'd1,5'd6,5'd8,5'd16,5'd31};
      7'd19: g = {5'd14,5'd17,5'd1,5'd6,5'd1,5'd17,5'd14};
      7'd20: g = {5'd2,5'd6,5'd10,5'd18,5'd31,5'd2,5'd2};
      7'd21: g = {5'd31,5'd16,5'd30,5'd1,5'd1,5'd17,5'd14};
      7'd22: g = {5'd6,5'd8,5'd16,5'd30,5'd17,5'd17,5'd14};
      7'd23: g = {5'd31,5'd1,5'd2,5'd4,5'd8,5'd8,5'd8};
      7'd24: g = {5'd14,5'd17,5'd17,5'd14,5'd17,5'd17,5'd14};
      7'd25: g = {5'd14,5'd17,5'd17,5'd15,5'd1,5'd2,5'd12};
      7'd26: g = {5'd0,5'd4,5'd0,5'd0,5'd0,5'd4,5'd0};
      7'd27: g = {5'd0,5'd4,5'd0,5'd0,5'd0,5'd4,5'd8};
      7'd28: g = {5'd2,5'd4,5'd8,5'd16,5'd8,5'd4,5'd2};
      7'd29: g = {5'd0,5'd0,5'd31,5'd0,5'd31,5'd0,5'd0};
      7'd30: g = {5'd8,5'd4,5'd2,5'd1,5'd2,5'd4,5'd8};
      7'd31: g = {5'd14,5'd17,5'd1,5'd2,5'd4,5'd0,5'd4};
      7'd32: g = {5'd14,5'd17,5'd21,5'd23,5'd22,5'd16,5'd14};
      7'd33: g = {5'd14,5'd17,5'd17,5'd31,5'd17,5'd17,5'd17};
      7'd34: g = {5'd30,5'd17,5'd17,5'd30,5'd17,5'd17,5'd30};
      7'd35: g = {5'd14,5'd17,5'd16,5'd16,5'd16,5'd17,5'd14};
      7'd36: g = {5'd30,5'd17,5'd17,5'd17,5'd17,5'd17,5'd30};
      7'd37: g = {5'd31,5'd16,5'd16,5'd30,5'd16,5'd16,5'd31};
      7'd38: g = {5'd31,5'd16,5'd16,5'd30,5'd16,5'd16,5'd16};
      7'd39: g = {5'd14,5'd17,5'd16,5'd23,5'd17,5'd17,5'd15};
      7'd40: g = {5'd17,5'd17,5'd17,5'd31,5'd17,5'd17,5'd17};
      7'd41: g = {5'd14,5'd4,5'd4,5'd4,5'd4,5'd4,5'd14};
      7'd42: g = {5'd1,5'd1,5'd1,5'd1,5'd1,5'd17,5'd14};
      7'd43: g = {5'd17,5'd18,5'd20,5'd24,5'd20,5'd18,5'd17};
      7'd44: g = {5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,5'd31};
      7'd45: g = {5'd17,5'd27,5'd21,5'd21,5'd17,5'd17,5'd17};
      7'd46: g = {5'd17,5'd25,5'd21,5'd19,5'd17,5'd17,5'd17};
      7'd47: g = {5'd14,5'd17,5'd17,5'd17,5'd17,5'd17,5'd14};
      7'd48: g = {5'd30,5'd17,5'd17,5'd30,5'd16,5'd16,5'd16};
      7'd49: g = {5'd14,5'd17,5'd17,5'd17,5'd21,5'd18,5'd13};
      7'd50: g = {5'd30,5'd17,5'd17,5'd30,5'd20,5'd18,5'd17};
      7'd51: g = {5'd14,5'd17,5'd16,5'd14,5'd1,5'd17,5'd14};
      7'd52: g = {5'd31,5'd4,5'd4,5'd4,5'd4,5'd4,5'd4};
      7'd53: g = {5'd17,5'd17,5'd17,5'd17,5'd17,5'd17,5'd14};
      7'd54: g = {5'd17,5'd17,5'd17,5'd17,5'd17,5'd10,5'd4};
      7'd55: g = {5'd17,5'd17,5'd17,5'd21,5'd21,5'd21,5'd10};
      7'd56: g = {5'd17,5'd17,5'd10,5'd4,5'd10,5'd17,5'd17};
      7'd57: g = {5'd17,5'd17,5'd10,5'd4,5'd4,5'd4,5'd4};
      7'd58: g = {5'd31,5'd1,5'd2,5'd4,5'd8,5'd16,5'd31};
      7'd59: g = {5'd14,5'd8,5'd8,5'd8,5'd8,5'd8,5'd14};
      7'd60: g = {5'd16,5'd16,5'd8,5'd4,5'd2,5'd1,5'd1};
      7'd61: g = {5'd14,5'd2,5'd2,5'd2,5'd2,5'd2,5'd14};
      7'd62: g = {5'd4,5'd10,5'd17,5'd0,5'd0,5'd0,5'd0};
      7'd63: g = {5'd0,5'd0,5'd0,5'd0,5'd0,5'd0,5'd31};
      7'd64: g = {5'd8,5'd4,5'd0,5'd0,5'd0,5'd0,5'd0};
      7'd65: g = {5'd0,5'd0,5'd14,5'd1,5'd15,5'd17,5'd15};
      7'd66: g = {5'd16,5'd16,5'd30,5'd17,5'd17,5'd17,5'd30};
      7'd67: g = {5'd0,5'd0,5'd14,5'd17,5'd16,5'd17,5'd14};
      7'd68: g = {5'd1,5'd1,5'd15,5'd17,5'd17,5'd17,5'd15};
      7'd69: g = {5'd0,5'd0,5'd14,5'd17,5'd31,5'd16,5'd14};
      7'd70: g = {5'd6,5'd8,5'd8,5'd30,5'd8,5'd8,5'd8};
      7'd71: g = {5'd0,5'd0,5'd15,5'd17,5'd15,5'd1,5'd14};
      7'd72: g = {5'd16,5'd16,5'd30,5'd17,5'd17,5'd17,5'd17};
      7'd73: g = {5'd4,5'd0,5'd12,5'd4,5'd4,5'd4,5'd14};
      7'd74: g = {5'd2,5'd0,5'd2,5'd2,5'd2,5'd18,5'd12};
      7'd75: g = {5'd16,5'd16,5'd18,5'd20,5'd24,5'd20,5'd18};
      7'd76: g = {5'd12,5'd4,5'd4,5'd4,5'd4,5'd4,5'd14};
      7'd77: g = {5'd0,5'd0,5'd26,5'd21,5'd21,5'd21,5'd21};
      7'd78: g = {5'd0,5'd0,5'd30,5'd17,5'd17,5'd17,5'd17};
      7'd79: g = {5'd0,5'd0,5'd14,5'd17,5'd17,5'd17,5'd14};
      7'd80: g = {5'd0,5'd0,5'd30,5'd17,5'd30,5'd16,5'd16};
      7'd81: g = {5'd0,5'd0,5'd15,5'd17,5'd15,5'd1,5'd1};
      7'd82: g = {5'd0,5'd0,5'd22,5'd24,5'd16,5'd16,5'd16};
      7'd83: g = {5'd0,5'd0,5'd15,5'd16,5'd14,5'd1,5'd30};
      7'd84: g = {5'd8,5'd8,5'd30,5'd8,5'd8,5'd8,5'd6};
      7'd85: g = {5'd0,5'd0,5'd17,5'd17,5'd17,5'd17,5'd15};
      7'd86: g = {5'd0,5'd0,5'd17,5'd17,5'd17,5'd10,5'd4};
      7'd87: g = {5'd0,5'd0,5'd17,5'd17,5'd21,5'd21,5'd10};
      7'd88: g = {5'd0,5'd0,5'd17,5'd10,5'd4,5'd10,5'd17};
      7'd89: g = {5'd0,5'd0,5'd17,5'd17,5'd15,5'd1,5'd14};
      7'd90: g = {5'd0,5'd0,5'd31,5'd2,5'd4,5'd8,5'd31};
      7'd91: g = {5'd2,5'd4,5'd4,5'd8,5'd4,5'd4,5'd2};
      7'd92: g = {5'd4,5'd4,5'd4,5'd4,5'd4,5'd4,5'd4};
      7'd93: g = {5'd8,5'd4,5'd4,5'd2,5'd4,5'd4,5'd8};
      7'd94: g = {5'd0,5'd8,5'd21,5'd2,5'd0,5'd0,5'd0};
      default: g = '0;
    endcase
    font_glyph = g;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/fgr_front.sv
// Front end: accepts characters, keeps the text cursor, looks up glyphs.
// Depends on fgr_pkg. Pushes one job per non-blank printable character.
`default_nettype none

module fgr_front import fgr_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cfg_t       cfg,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire char_item_t in_data,
  output logic            job_valid,
  input  wire logic       job_ready,
  output glyph_job_t      job_data
);

  logic [15:0] cursor_column, cursor_column_next;
  logic [15:0] line_row, line_row_next;
  logic [15:0] base_x, base_y;
  logic        in_fire, is_newline, printable;
  glyph_t      glyph;

  assign in_ready = job_ready;
  assign in_fire  = in_valid && in_ready;

  assign base_x = in_data.first ? {4'd0, cfg.origin_x} : cursor_column;
  assign base_y = in_data.first ? {4'd0, cfg.origin_y} : line_row;

  assign is_newline = (in_data.char_code == NEWLINE_CODE);
  assign printable  = (in_data.char_code >= FIRST_CODE) && (in_data.char_code <= LAST_CODE);
  assign glyph      = font_glyph(GLYPH_IDX_W'(in_data.char_code - FIRST_CODE));

  always_comb begin
    if (is_newline) begin
      cursor_column_next = {4'd0, cfg.origin_x};
      line_row_next      = sat_add(base_y, {cfg.pixel_scale, 3'b000} + OFS_W'(2));
    end else begin
      cursor_column_next = sat_add(base_x, OFS_W'(cfg.pixel_scale) * OFS_W'(6));
      line_row_next      = base_y;
    end
  end

  // blank glyphs (space) produce no job
  assign job_valid         = in_valid && printable && (glyph != '0);
  assign job_data.glyph    = glyph;
  assign job_data.cursor_x = base_x;
  assign job_data.cursor_y = base_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_column <= '0;
      line_row      <= '0;
    end else if (in_fire) begin
      cursor_column <= cursor_column_next;
      line_row      <= line_row_next;
    end
  end

  a_newline_home: assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_data.char_code == NEWLINE_CODE)
      |=> cursor_column == {4'd0, $past(cfg.origin_x)})
    else $error("newline did not return cursor to origin column");

  a_line_holds: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !is_newline) |=> line_row == $past(base_y))
    else $error("line moved on a non-newline item");

  a_push_only_visible: assert property (@(posedge clk) disable iff (rst)
    (job_valid && job_ready) |-> (in_fire && in_data.char_code != NEWLINE_CODE))
    else $error("job pushed for a non-glyph item");

endmodule

`default_nettype wire

>>> hw/rtl/fgr_queue.sv
// Small job queue between the front end and the dot emitter.
// Depends on fgr_pkg for the job type. DEPTH must be at least 2.
`default_nettype none

module fgr_queue import fgr_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push_valid,
  output logic            push_ready,
  input  wire glyph_job_t push_data,
  output logic            pop_valid,
  input  wire logic       pop_ready,
  output glyph_job_t      pop_data
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  glyph_job_t    mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          push_fire, pop_fire;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push_fire) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_fire) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push_fire && !pop_fire) begin
        count <= count + 1'b1;
      end else if (pop_fire && !push_fire) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count beyond depth");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push_fire && !pop_fire) |=> count == $past(count) + 1'b1)
    else $error("queue count missed a push");

  a_ptr_track: assert property (@(posedge clk) disable iff (rst)
    (count == '0 || count == CW'(DEPTH)) |-> wr_ptr == rd_ptr)
    else $error("queue pointers out of step with count");

endmodule

`default_nettype wire

>>> hw/rtl/fgr_back.sv
// Back end: walks the set dots of one glyph job, one square per cycle while the output is not stalled.
// Depends on fgr_pkg. Output register decouples from the downstream sink.
`default_nettype none

module fgr_back import fgr_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cfg_t       cfg,
  input  wire logic       job_valid,
  output logic            job_ready,
  input  wire glyph_job_t job_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output dot_item_t       out_data
);

  logic             busy;
  glyph_t           mask, mask_after;
  logic [15:0]      cur_x, cur_y;
  logic [ROW_W-1:0] row_sel;
  logic [COL_W-1:0] col_sel;
  logic [GLYPH_COLUMNS-1:0] row_bits;
  logic             row_found, col_found;
  logic             emit, dot_last;
  dot_item_t        dot;

  // first non-empty row, then first set column in it
  always_comb begin
    row_sel   = '0;
    row_found = 1'b0;
    for (int r = 0; r < GLYPH_ROWS; r++) begin
      if (!row_found && (mask[r] != '0)) begin
        row_found = 1'b1;
        row_sel   = ROW_W'(r);
      end
    end
    row_bits  = mask[row_sel];
    col_sel   = '0;
    col_found = 1'b0;
    for (int c = 0; c < GLYPH_COLUMNS; c++) begin
      if (!col_found && row_bits[GLYPH_COLUMNS-1-c]) begin
        col_found = 1'b1;
        col_sel   = COL_W'(c);
      end
    end
    mask_after = mask;
    mask_after[row_sel][COL_W'(GLYPH_COLUMNS - 1) - col_sel] = 1'b0;
  end

  assign dot_last = (mask_after == '0);

  always_comb begin
    dot.dot_x     = sat_add(cur_x, OFS_W'(col_sel) * OFS_W'(cfg.pixel_scale));
    dot.dot_y     = sat_add(cur_y, OFS_W'(row_sel) * OFS_W'(cfg.pixel_scale));
    dot.dot_size  = cfg.pixel_scale;
    dot.out_red   = cfg.color_red;
    dot.out_green = cfg.color_green;
    dot.out_blue  = cfg.color_blue;
    dot.last      = dot_last;
  end

  assign emit      = busy && (!out_valid || out_ready);
  assign job_ready = !busy || (emit && dot_last);

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= dot;
    end
    if (job_valid && job_ready) begin
      mask  <= job_data.glyph;
      cur_x <= job_data.cursor_x;
      cur_y <= job_data.cursor_y;
    end else if (emit) begin
      mask <= mask_after;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (job_valid && job_ready) begin
        busy <= 1'b1;
      end else if (emit && dot_last) begin
        busy <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_busy_has_dots: assert property (@(posedge clk) disable iff (rst)
    busy |-> mask != '0)
    else $error("emitter busy with an empty glyph");

  a_last_ends_job: assert property (@(posedge clk) disable iff (rst)
    (emit && dot_last && !job_valid) |=> !busy)
    else $error("emitter stayed busy after the last dot");

  a_emit_lands: assert property (@(posedge clk) disable iff (rst)
    emit |=> out_valid)
    else $error("emitted dot not presented");

endmodule

`default_nettype wire

>>> hw/rtl/font_glyph_rasterizer.sv
// Top level of the 5x7 font rasterizer: configuration registers, front end,
// job queue and dot emitter. Depends on fgr_pkg, fgr_front, fgr_queue, fgr_back.
//
// Text rasterizer. Each input item is one character byte plus a "first" flag
// that homes the cursor to (origin_x, origin_y) before the character. A
// printable code (32..126) produces one output item per lit dot of its 5x7
// glyph, rows top to bottom and columns left to right, each a square of side
// pixel_scale at the cursor offset by (col, row) * pixel_scale; "last" marks
// the final square of a character. The cursor then moves right by
// 6 * pixel_scale; a newline (10) returns to origin_x and moves down by
// 8 * pixel_scale + 2; all other codes emit nothing and just advance.
// Coordinates saturate at 65535. Input items are taken one per cycle while the
// job queue (QUEUE_DEPTH entries) has room; the dot emitter delivers one
// square per cycle while out_ready is high, so a character yields one output
// item per lit dot (0 for blanks, newlines and other codes, up to 20 for the
// densest glyphs). Sustained throughput is therefore set by the dot emitter:
// one output item per clock while out_ready is high. Configuration writes
// take effect on the next cycle and are always accepted; indexes 6 and 7 are
// ignored. Write configuration only when no character is in flight.
`default_nettype none

module font_glyph_rasterizer import fgr_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // character items
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire char_item_t  in_data,
  // dot items
  output logic             out_valid,
  input  wire logic        out_ready,
  output dot_item_t        out_data,
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [11:0] cfg_data
);

  cfg_t       cfg;
  logic       job_push_valid, job_push_ready;
  glyph_job_t job_push_data;
  logic       job_pop_valid, job_pop_ready;
  glyph_job_t job_pop_data;

  // Register file; no back-pressure on writes.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_x    <= '0;
      cfg.origin_y    <= '0;
      cfg.pixel_scale <= 4'd1;
      cfg.color_red   <= 8'd255;
      cfg.color_green <= 8'd255;
      cfg.color_blue  <= 8'd255;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ORIGIN_X:    cfg.origin_x    <= cfg_data;
        REG_ORIGIN_Y:    cfg.origin_y    <= cfg_data;
        REG_PIXEL_SCALE: cfg.pixel_scale <= cfg_data[3:0];
        REG_COLOR_RED:   cfg.color_red   <= cfg_data[7:0];
        REG_COLOR_GREEN: cfg.color_green <= cfg_data[7:0];
        REG_COLOR_BLUE:  cfg.color_blue  <= cfg_data[7:0];
        default: ;  // unused indexes are dropped
      endcase
    end
  end

  // Front end: cursor bookkeeping and glyph lookup, one item per cycle while the queue has room.
  fgr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .job_valid (job_push_valid),
    .job_ready (job_push_ready),
    .job_data  (job_push_data)
  );

  // Queue lets the front keep taking characters while the emitter drains.
  fgr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (job_push_valid),
    .push_ready (job_push_ready),
    .push_data  (job_push_data),
    .pop_valid  (job_pop_valid),
    .pop_ready  (job_pop_ready),
    .pop_data   (job_pop_data)
  );

  // Back end: one square per cycle into a registered output, while the sink accepts.
  fgr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .job_valid (job_pop_valid),
    .job_ready (job_pop_ready),
    .job_data  (job_pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
